[src/hbcs_pkg.sv]
// Shared types, register offsets and reset tables for the host bridge configuration space.
// Used by hbcs_cfg_mem, hbcs_core and host_bridge_config_space; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package hbcs_pkg;

    // Operation carried by an input beat.
    typedef enum logic [1:0] {
        MODE_WRITE  = 2'd0,
        MODE_READ   = 2'd1,
        MODE_SMIACT = 2'd2,
        MODE_QUERY  = 2'd3
    } t_mode;

    localparam int CFG_DEPTH = 256;
    localparam int SEGMENTS  = 16;
    localparam int BAR_BYTES = 24;
    localparam int ROW_BYTES = 5;
    localparam int ROW_BITS  = 8 * ROW_BYTES;

    // Register offsets.
    localparam logic [7:0] ADDR_ID_LAST  = 8'h0B;
    localparam logic [7:0] ADDR_BAR_LO   = 8'h10;
    localparam logic [7:0] ADDR_BAR_HI   = 8'h27;
    localparam logic [7:0] ADDR_HOLE     = 8'h57;
    localparam logic [7:0] ADDR_PAM0     = 8'h59;
    localparam logic [7:0] ADDR_PAM_LO   = 8'h5A;
    localparam logic [7:0] ADDR_PAM_HI   = 8'h5F;
    localparam logic [7:0] ADDR_ROW_LO   = 8'h60;
    localparam logic [7:0] ADDR_ROW_HI   = 8'h64;
    localparam logic [7:0] ADDR_SMRAM    = 8'h72;

    // Value every BAR takes when a write access ends inside the BAR window.
    localparam logic [31:0] BAR_FORCE    = 32'hFFFF_FFFD;

    // SMRAM control bits of register 0x72.
    localparam int SMRAM_OPEN_BIT  = 6;
    localparam int SMRAM_CLOSE_BIT = 5;
    localparam int SMRAM_LOCK_BIT  = 4;
    localparam int SMRAM_ENA_BIT   = 3;

    localparam logic [7:0]          SMRAM_RESET = 8'h02;
    localparam logic [7:0]          ROW_RESET   = 8'h02;
    localparam logic [ROW_BITS-1:0] ROWS_RESET  = 40'h02_0202_0202;

    // Hole code that the hardware treats as no hole.
    localparam logic [1:0] HOLE_NONE     = 2'd0;
    localparam logic [1:0] HOLE_RESERVED = 2'd3;

    // One write beat towards the byte store.
    typedef struct packed {
        logic       we;
        logic [7:0] addr;
        logic [7:0] data;
    } t_mem_wr;

    // Fixed identification bytes at offsets 0x00 to 0x0B.
    function automatic logic [7:0] id_byte(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'h0:    v = 8'h86;
            4'h1:    v = 8'h80;
            4'h2:    v = 8'h22;
            4'h3:    v = 8'h01;
            4'h4:    v = 8'h06;
            4'h7:    v = 8'h02;
            4'hB:    v = 8'h06;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Power-on contents of the bytes held in the store.
    function automatic logic [7:0] mem_default(input logic [7:0] addr);
        logic [7:0] v;
        case (addr)
            8'h52:   v = 8'h02;
            8'h53:   v = 8'h14;
            8'h56:   v = 8'h52;
            8'h57:   v = 8'h01;
            8'h59:   v = 8'h0F;
            8'h69:   v = 8'h03;
            8'h70:   v = 8'h20;
            8'h74:   v = 8'h0E;
            8'h78:   v = 8'h23;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[src/hbcs_cfg_mem.sv]
// 256 x 8 byte store for the plain configuration registers, with one valid bit per byte.
// Uses hbcs_pkg for the write beat type and the power-on contents.
`timescale 1ns / 1ps
`default_nettype none

module hbcs_cfg_mem (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire hbcs_pkg::t_mem_wr i_wr,
    input  wire logic             i_rd_en,
    input  wire logic [7:0]       i_rd_addr,
    output logic [7:0]            o_rd_data
);

    logic [7:0]                     r_mem [hbcs_pkg::CFG_DEPTH];
    logic [hbcs_pkg::CFG_DEPTH-1:0] r_valid;
    logic [7:0]                     r_rd_data;

    // Storage array.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read. A write landing on the same byte in the same cycle is passed
    // straight through, and a byte never written reads as its power-on value.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr.we && (i_wr.addr == i_rd_addr)) begin
                r_rd_data <= i_wr.data;
            end else if (r_valid[i_rd_addr]) begin
                r_rd_data <= r_mem[i_rd_addr];
            end else begin
                r_rd_data <= hbcs_pkg::mem_default(i_rd_addr);
            end
        end
    end

    // Written flags, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.we) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[src/hbcs_core.sv]
// Execute stage of the configuration space: special registers, routing maps, SMRAM
// control and the result register. Uses hbcs_pkg; drives the byte store in hbcs_cfg_mem.
`timescale 1ns / 1ps
`default_nettype none

module hbcs_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [hbcs_pkg::ROW_BITS-1:0] i_row_bounds,
    // Input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_mode,
    input  wire logic [7:0]                    i_reg_addr,
    input  wire logic [7:0]                    i_write_data,
    input  wire logic                          i_access_done,
    input  wire logic                          i_smiact_in,
    input  wire logic [3:0]                    i_segment,
    input  wire logic                          i_is_write,
    // Byte store
    output hbcs_pkg::t_mem_wr                  o_mem_wr,
    output logic                               o_mem_rd_en,
    input  wire logic [7:0]                    i_mem_rd_data,
    // Output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [7:0]                         o_read_data,
    output logic                               o_routes_to_dram,
    output logic                               o_smram_open,
    output logic                               o_smram_data_ok,
    output logic                               o_smram_lock_out,
    output logic [1:0]                         o_memory_hole
);

    // Input stage
    logic                   r_s_valid;
    hbcs_pkg::t_mode        r_s_mode;
    logic [7:0]             r_s_addr;
    logic [7:0]             r_s_wdata;
    logic                   r_s_done;
    logic                   r_s_smi;
    logic [3:0]             r_s_seg;
    logic                   r_s_isw;

    // Architectural state outside the byte store
    logic [7:0]             r_bar [hbcs_pkg::BAR_BYTES];
    logic [7:0]             r_row [hbcs_pkg::ROW_BYTES];
    logic [7:0]             r_smram_byte;
    logic [hbcs_pkg::SEGMENTS-1:0] r_read_map;
    logic [hbcs_pkg::SEGMENTS-1:0] r_write_map;
    logic                   r_lock;
    logic                   r_open;
    logic                   r_data_ok;
    logic                   r_smiact;
    logic [1:0]             r_hole;

    // Result register
    logic                   r_o_valid;
    logic [7:0]             r_o_read_data;
    logic                   r_o_route;
    logic                   r_o_open;
    logic                   r_o_data_ok;
    logic                   r_o_lock;
    logic [1:0]             r_o_hole;

    // Next values
    logic [7:0]             n_bar [hbcs_pkg::BAR_BYTES];
    logic [7:0]             n_row [hbcs_pkg::ROW_BYTES];
    logic [7:0]             n_smram_byte;
    logic [hbcs_pkg::SEGMENTS-1:0] n_read_map;
    logic [hbcs_pkg::SEGMENTS-1:0] n_write_map;
    logic                   n_lock;
    logic                   n_open;
    logic                   n_data_ok;
    logic                   n_smiact;
    logic [1:0]             n_hole;
    logic [7:0]             n_read_data;
    logic                   n_route;

    logic                   advance;
    logic                   accept;
    logic                   is_wr;
    logic                   in_id;
    logic                   in_bar;
    logic                   in_row;
    logic                   in_smram;
    logic                   special;
    logic [7:0]             bar_off;
    logic [4:0]             bar_idx;
    logic [7:0]             row_off;
    logic [2:0]             row_idx;
    logic [7:0]             pam_off;
    logic [2:0]             pam_idx;
    logic                   pam0_hit;
    logic                   pam_hit;
    logic                   sm_upd;
    logic [7:0]             sm_c;
    logic                   sm_lock;
    logic [7:0]             sm_c2;
    logic [1:0]             setting;
    logic [1:0]             hole_code;

    // Handshake: the stage moves on whenever the result register is free or draining.
    assign advance    = r_s_valid && (!r_o_valid || !i_out_stall);
    assign o_in_stall = r_s_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    // Address decode of the staged beat.
    assign is_wr    = (r_s_mode == hbcs_pkg::MODE_WRITE);
    assign in_id    = (r_s_addr <= hbcs_pkg::ADDR_ID_LAST);
    assign in_bar   = (r_s_addr inside {[hbcs_pkg::ADDR_BAR_LO : hbcs_pkg::ADDR_BAR_HI]});
    assign in_row   = (r_s_addr inside {[hbcs_pkg::ADDR_ROW_LO : hbcs_pkg::ADDR_ROW_HI]});
    assign in_smram = (r_s_addr == hbcs_pkg::ADDR_SMRAM);
    assign special  = in_id || in_bar || in_row || in_smram;
    assign bar_off  = r_s_addr - hbcs_pkg::ADDR_BAR_LO;
    assign bar_idx  = bar_off[4:0];
    assign row_off  = r_s_addr - hbcs_pkg::ADDR_ROW_LO;
    assign row_idx  = row_off[2:0];
    assign pam_off  = r_s_addr - hbcs_pkg::ADDR_PAM_LO;
    assign pam_idx  = pam_off[2:0];
    assign pam0_hit = is_wr && (r_s_addr == hbcs_pkg::ADDR_PAM0);
    assign pam_hit  = is_wr &&
                      (r_s_addr inside {[hbcs_pkg::ADDR_PAM_LO : hbcs_pkg::ADDR_PAM_HI]});

    // BAR bytes: forced as a whole when a write access ends inside the window.
    always_comb begin
        for (int i = 0; i < hbcs_pkg::BAR_BYTES; i++) begin
            if (is_wr && in_bar && r_s_done) begin
                n_bar[i] = hbcs_pkg::BAR_FORCE[8*(i%4) +: 8];
            end else if (is_wr && in_bar && (bar_idx == 5'(i))) begin
                n_bar[i] = r_s_wdata;
            end else begin
                n_bar[i] = r_bar[i];
            end
        end
    end

    // DRAM row bytes: any write to the group reloads all of them from the detected bounds.
    always_comb begin
        for (int i = 0; i < hbcs_pkg::ROW_BYTES; i++) begin
            n_row[i] = (is_wr && in_row) ? i_row_bounds[8*i +: 8] : r_row[i];
        end
    end

    // SMRAM control, updated on a write to its register or on an SMIACT beat.
    always_comb begin
        sm_upd       = (is_wr && in_smram) || (r_s_mode == hbcs_pkg::MODE_SMIACT);
        n_smiact     = (r_s_mode == hbcs_pkg::MODE_SMIACT) ? r_s_smi : r_smiact;
        sm_c         = is_wr ? r_s_wdata : r_smram_byte;
        sm_lock      = sm_c[hbcs_pkg::SMRAM_LOCK_BIT] || r_lock;
        sm_c2        = sm_c;
        if (sm_lock) begin
            sm_c2[hbcs_pkg::SMRAM_OPEN_BIT] = 1'b0;
        end
        n_smram_byte = r_smram_byte;
        n_lock       = r_lock;
        n_open       = r_open;
        n_data_ok    = r_data_ok;
        if (sm_upd) begin
            n_smram_byte = sm_c2;
            n_lock       = sm_lock;
            if (sm_c2[hbcs_pkg::SMRAM_OPEN_BIT]) begin
                n_open = sm_c2[hbcs_pkg::SMRAM_ENA_BIT];
            end else begin
                n_open = n_smiact && sm_c2[hbcs_pkg::SMRAM_ENA_BIT];
            end
            n_data_ok = !sm_c2[hbcs_pkg::SMRAM_CLOSE_BIT];
        end
    end

    // Memory hole select; the reserved code means no hole.
    always_comb begin
        hole_code = r_s_wdata[7:6];
        n_hole    = r_hole;
        if (is_wr && (r_s_addr == hbcs_pkg::ADDR_HOLE)) begin
            n_hole = (hole_code == hbcs_pkg::HOLE_RESERVED) ? hbcs_pkg::HOLE_NONE : hole_code;
        end
    end

    // Shadow segment routing. PAM0 covers the top four segments with one setting;
    // each later PAM byte covers two segments, one per nibble.
    always_comb begin
        n_read_map  = r_read_map;
        n_write_map = r_write_map;
        for (int i = 0; i < hbcs_pkg::SEGMENTS; i++) begin
            setting = i[0] ? r_s_wdata[5:4] : r_s_wdata[1:0];
            if (pam0_hit && (i >= hbcs_pkg::SEGMENTS - 4)) begin
                n_read_map[i]  = r_s_wdata[4];
                n_write_map[i] = r_s_wdata[5];
            end else if (pam_hit && (pam_idx == 3'(i / 2))) begin
                n_read_map[i]  = setting[0];
                n_write_map[i] = setting[1];
            end
        end
    end

    // Result byte, taken after this beat's own update.
    always_comb begin
        if (in_id) begin
            n_read_data = hbcs_pkg::id_byte(r_s_addr[3:0]);
        end else if (in_bar) begin
            n_read_data = n_bar[bar_idx];
        end else if (in_row) begin
            n_read_data = n_row[row_idx];
        end else if (in_smram) begin
            n_read_data = n_smram_byte;
        end else if (is_wr) begin
            n_read_data = r_s_wdata;
        end else begin
            n_read_data = i_mem_rd_data;
        end
        n_route = 1'b0;
        if (r_s_mode == hbcs_pkg::MODE_QUERY) begin
            n_route = r_s_isw ? r_write_map[r_s_seg] : r_read_map[r_s_seg];
        end
    end

    // Plain bytes go to the store as the beat leaves the stage.
    assign o_mem_wr    = {advance && is_wr && !special, r_s_addr, r_s_wdata};
    assign o_mem_rd_en = accept;

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid    <= 1'b0;
            r_o_valid    <= 1'b0;
            for (int i = 0; i < hbcs_pkg::BAR_BYTES; i++) begin
                r_bar[i] <= 8'h00;
            end
            for (int i = 0; i < hbcs_pkg::ROW_BYTES; i++) begin
                r_row[i] <= hbcs_pkg::ROW_RESET;
            end
            r_smram_byte <= hbcs_pkg::SMRAM_RESET;
            r_read_map   <= '0;
            r_write_map  <= '0;
            r_lock       <= 1'b0;
            r_open       <= 1'b0;
            r_data_ok    <= 1'b1;
            r_smiact     <= 1'b0;
            r_hole       <= hbcs_pkg::HOLE_NONE;
        end else begin
            if (accept) begin
                r_s_valid <= 1'b1;
            end else if (advance) begin
                r_s_valid <= 1'b0;
            end
            if (advance) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
            if (advance) begin
                r_bar        <= n_bar;
                r_row        <= n_row;
                r_smram_byte <= n_smram_byte;
                r_read_map   <= n_read_map;
                r_write_map  <= n_write_map;
                r_lock       <= n_lock;
                r_open       <= n_open;
                r_data_ok    <= n_data_ok;
                r_smiact     <= n_smiact;
                r_hole       <= n_hole;
            end
        end
    end

    // Stage and result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s_mode  <= hbcs_pkg::t_mode'(i_mode);
            r_s_addr  <= i_reg_addr;
            r_s_wdata <= i_write_data;
            r_s_done  <= i_access_done;
            r_s_smi   <= i_smiact_in;
            r_s_seg   <= i_segment;
            r_s_isw   <= i_is_write;
        end
        if (advance) begin
            r_o_read_data <= n_read_data;
            r_o_route     <= n_route;
            r_o_open      <= n_open;
            r_o_data_ok   <= n_data_ok;
            r_o_lock      <= n_lock;
            r_o_hole      <= n_hole;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_read_data      = r_o_read_data;
    assign o_routes_to_dram = r_o_route;
    assign o_smram_open     = r_o_open;
    assign o_smram_data_ok  = r_o_data_ok;
    assign o_smram_lock_out = r_o_lock;
    assign o_memory_hole    = r_o_hole;

    // Once set, the SMRAM lock holds until reset.
    a_lock_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lock |=> r_lock)
        else $error("SMRAM lock cleared without reset");

    // While locked the open bit of the control byte can never be set.
    a_lock_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lock |-> !r_smram_byte[hbcs_pkg::SMRAM_OPEN_BIT])
        else $error("SMRAM open bit set while locked");

    // The reserved hole code is never stored.
    a_hole_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hole != hbcs_pkg::HOLE_RESERVED)
        else $error("reserved memory hole code stored");

    // A stalled stage keeps its beat.
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s_valid && !advance) |=> (r_s_valid && $stable(r_s_addr) && $stable(r_s_mode)))
        else $error("staged beat lost while stalled");

endmodule

`default_nettype wire

[src/host_bridge_config_space.sv]
// Top level of the host bridge configuration space: row bounds register and wiring.
// Depends on hbcs_pkg, hbcs_cfg_mem and hbcs_core.
//
//  Channel  | Handshake            | Carries
//  ---------+----------------------+-------------------------------------------------
//  in       | i_in_valid/o_in_stall | mode, reg_addr, write_data, access_done, smiact,
//           |                      | segment, is_write
//  out      | o_out_valid/i_out_stall | read_data, route, SMRAM status, memory hole
//  cfg      | i_cfg_valid/o_cfg_ready | 40-bit detected DRAM row bounds
//
// One beat is accepted per cycle while o_in_stall is low. The accepting edge loads the input
// stage, and the result register is loaded from the stage when it advances, so a result is
// offered once its beat has left the stage. The byte store read issued at acceptance is ready
// while the beat sits in the stage. Reset is synchronous and needs no clearing pass: each
// store byte has a written flag. A stalled output holds the stage and stalls the input.
`timescale 1ns / 1ps
`default_nettype none

module host_bridge_config_space (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [hbcs_pkg::ROW_BITS-1:0] i_cfg_data,
    // Input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_mode,
    input  wire logic [7:0]                    i_reg_addr,
    input  wire logic [7:0]                    i_write_data,
    input  wire logic                          i_access_done,
    input  wire logic                          i_smiact_in,
    input  wire logic [3:0]                    i_segment,
    input  wire logic                          i_is_write,
    // Output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [7:0]                         o_read_data,
    output logic                               o_routes_to_dram,
    output logic                               o_smram_open,
    output logic                               o_smram_data_ok,
    output logic                               o_smram_lock_out,
    output logic [1:0]                         o_memory_hole
);

    logic [hbcs_pkg::ROW_BITS-1:0] r_row_bounds;
    hbcs_pkg::t_mem_wr             mem_wr;
    logic                          mem_rd_en;
    logic [7:0]                    mem_rd_data;

    // Detected row bounds, written by a configuration beat.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bounds <= hbcs_pkg::ROWS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_row_bounds <= i_cfg_data;
        end
    end

    // Plain configuration bytes.
    hbcs_cfg_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (mem_wr),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (i_reg_addr),
        .o_rd_data (mem_rd_data)
    );

    // Execute stage and result register.
    hbcs_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_row_bounds     (r_row_bounds),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_reg_addr       (i_reg_addr),
        .i_write_data     (i_write_data),
        .i_access_done    (i_access_done),
        .i_smiact_in      (i_smiact_in),
        .i_segment        (i_segment),
        .i_is_write       (i_is_write),
        .o_mem_wr         (mem_wr),
        .o_mem_rd_en      (mem_rd_en),
        .i_mem_rd_data    (mem_rd_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_read_data      (o_read_data),
        .o_routes_to_dram (o_routes_to_dram),
        .o_smram_open     (o_smram_open),
        .o_smram_data_ok  (o_smram_data_ok),
        .o_smram_lock_out (o_smram_lock_out),
        .o_memory_hole    (o_memory_hole)
    );

endmodule

`default_nettype wire
